// ===== rtl/stup_pkg.sv =====
// shared constants and types for the string to unsigned parser
`default_nettype none

package stup_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_CHARS   = 4096;
  localparam int COUNT_W     = $clog2(MAX_CHARS + 1);
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int VALUE_OUT_W = 32;
  localparam int OFFSET_W    = 13;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  // register index taken from paddr[2]
  localparam logic REG_NUMBER_BASE = 1'b0;

  typedef struct packed {
    logic [VALUE_OUT_W-1:0] parsed_value;
    logic                   parse_done;
    logic [OFFSET_W-1:0]    end_offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/stup_engine.sv =====
// parse state machine with one multiply-add per character and the result register
`default_nettype none

module stup_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [stup_pkg::CHAR_W-1:0] char_code,
  input  logic                       start_of_string,
  input  logic [stup_pkg::BASE_W-1:0] number_base,
  output stup_pkg::result_t          result
);
  import stup_pkg::*;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO_AUTO,
    PH_ZERO_HEX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam logic [BASE_W-1:0] NO_DIGIT = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_8   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_10  = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_16  = BASE_W'(16);
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

  function automatic logic [BASE_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = NO_DIGIT;
    if (c inside {[8'h30:8'h39]}) begin
      d = BASE_W'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7a]}) begin
      d = BASE_W'(c - 8'h57);
    end else if (c inside {[8'h41:8'h5a]}) begin
      d = BASE_W'(c - 8'h37);
    end
    return d;
  endfunction

  phase_t                 phase;
  logic [BASE_W-1:0]      active_base;
  logic [VALUE_WIDTH-1:0] accumulator;
  logic                   minus_seen;
  logic [COUNT_W-1:0]     committed_offset;

  phase_t                 phase_cur, phase_next;
  logic [BASE_W-1:0]      base_cur, base_next, mul_base;
  logic [VALUE_WIDTH-1:0] acc_cur, acc_next;
  logic                   minus_cur, minus_next;
  logic [COUNT_W-1:0]     offset_cur, offset_next;
  logic                   bump, do_prefix, do_digit, digit_ok, blank;
  logic [BASE_W-1:0]      digit;
  logic [VALUE_WIDTH+BASE_W-1:0] product;
  logic [VALUE_WIDTH-1:0] value_signed;
  logic [VALUE_WIDTH+VALUE_OUT_W-1:0] value_wide;
  logic [COUNT_W+OFFSET_W-1:0]        offset_wide;

  assign digit    = char_digit(char_code);
  assign blank    = char_code inside {8'h20, [8'h09:8'h0d]};
  assign digit_ok = (digit != NO_DIGIT) && (digit < mul_base);
  assign product  = (VALUE_WIDTH + BASE_W)'(acc_cur) * (VALUE_WIDTH + BASE_W)'(mul_base);

  always_comb begin
    // a start character begins from a cleared state
    phase_cur  = start_of_string ? PH_SPACE : phase;
    base_cur   = start_of_string ? number_base : active_base;
    acc_cur    = start_of_string ? '0 : accumulator;
    minus_cur  = start_of_string ? 1'b0 : minus_seen;
    offset_cur = start_of_string ? '0 : committed_offset;

    phase_next  = phase_cur;
    base_next   = base_cur;
    acc_next    = acc_cur;
    minus_next  = minus_cur;
    offset_next = offset_cur;
    mul_base    = base_cur;
    bump        = 1'b0;
    do_prefix   = 1'b0;
    do_digit    = 1'b0;

    case (phase_cur)
      PH_SPACE: begin
        if (blank) begin
          bump = 1'b1;
        end else if (char_code == CH_MINUS || char_code == CH_PLUS) begin
          minus_next = (char_code == CH_MINUS);
          bump       = 1'b1;
          phase_next = PH_PREFIX;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PH_PREFIX: do_prefix = 1'b1;
      PH_ZERO_AUTO: begin
        phase_next = PH_DIGITS;
        if (char_code == CH_X_LO || char_code == CH_X_UP) begin
          base_next = BASE_16;
          bump      = 1'b1;
        end else begin
          base_next = BASE_8;
          mul_base  = BASE_8;
          do_digit  = 1'b1;
        end
      end
      PH_ZERO_HEX: begin
        phase_next = PH_DIGITS;
        if (char_code == CH_X_LO || char_code == CH_X_UP) begin
          bump = 1'b1;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default:   phase_next = PH_DONE;
    endcase

    // radix prefix resolution
    if (do_prefix) begin
      if (base_cur == '0) begin
        if (char_code == CH_ZERO) begin
          bump       = 1'b1;
          phase_next = PH_ZERO_AUTO;
        end else begin
          base_next = BASE_10;
          mul_base  = BASE_10;
          do_digit  = 1'b1;
        end
      end else if (base_cur == BASE_16 && char_code == CH_ZERO) begin
        bump       = 1'b1;
        phase_next = PH_ZERO_HEX;
      end else begin
        do_digit = 1'b1;
      end
    end

    if (do_digit) begin
      if (digit_ok) begin
        acc_next   = product[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit);
        bump       = 1'b1;
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (bump && offset_cur < COUNT_W'(MAX_CHARS)) begin
      offset_next = offset_cur + COUNT_W'(1);
    end
  end

  assign value_signed = minus_next ? (VALUE_WIDTH'(0) - acc_next) : acc_next;
  assign value_wide   = {{VALUE_OUT_W{1'b0}}, value_signed};
  assign offset_wide  = {{OFFSET_W{1'b0}}, offset_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SPACE;
      active_base      <= '0;
      accumulator      <= '0;
      minus_seen       <= 1'b0;
      committed_offset <= '0;
    end else if (step) begin
      phase                <= phase_next;
      active_base          <= base_next;
      accumulator          <= acc_next;
      minus_seen           <= minus_next;
      committed_offset     <= offset_next;
      result.parsed_value  <= value_wide[VALUE_OUT_W-1:0];
      result.parse_done    <= (phase_next == PH_DONE);
      result.end_offset    <= offset_wide[OFFSET_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/string_to_unsigned_parser.sv =====
// top level of the streaming string to unsigned integer parser
`default_nettype none

// Takes one character per transfer and returns one result per character:
// the value parsed so far (negated modulo 2^32 after a '-' sign), a done flag
// and the end-pointer offset. A character with start_of_string set begins a
// new string and samples number_base (0 detects octal, decimal or hex from
// the prefix). Each character passes through the input register and then the
// parse stage, whose single multiply-add by the radix updates the state; a
// new character is taken every cycle unless a stalled result holds it back.
// A stalled result holds the parse stage; the input register still takes one
// more character while the output waits.

module string_to_unsigned_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stup_pkg::ADDR_W-1:0]   paddr,
  input  logic [stup_pkg::DATA_W-1:0]   pwdata,
  output logic [stup_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stup_pkg::CHAR_W-1:0]   char_code,
  input  logic                          start_of_string,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stup_pkg::VALUE_OUT_W-1:0] parsed_value,
  output logic                          parse_done,
  output logic [stup_pkg::OFFSET_W-1:0] end_offset
);
  import stup_pkg::*;

  logic [BASE_W-1:0] number_base;
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_start;
  logic              advance;
  logic              load;
  logic              cfg_write;
  result_t           result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUMBER_BASE);
  assign prdata    = (paddr[2] == REG_NUMBER_BASE) ? DATA_W'(number_base) : '0;

  // parse stage moves unless a valid result is held
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      number_base <= '0;
    end else begin
      if (load) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (cfg_write) begin
        number_base <= pwdata[BASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_char  <= char_code;
      s1_start <= start_of_string;
    end
  end

  stup_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .step            (s1_valid && advance),
    .char_code       (s1_char),
    .start_of_string (s1_start),
    .number_base     (number_base),
    .result          (result)
  );

  assign parsed_value = result.parsed_value;
  assign parse_done   = result.parse_done;
  assign end_offset   = result.end_offset;

endmodule

`default_nettype wire

// ===== rtl/string_to_unsigned_parser_checker.sv =====
// port-level checks for the string to unsigned parser, bound to the top level
`default_nettype none

module string_to_unsigned_parser_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [stup_pkg::VALUE_OUT_W-1:0]  parsed_value,
  input logic                              parse_done,
  input logic [stup_pkg::OFFSET_W-1:0]     end_offset
);
  import stup_pkg::*;

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(parsed_value)
      && $stable(parse_done) && $stable(end_offset))
    else $error("stalled result changed");

  // input only waits behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // nothing left over from before reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // offset saturates at the character limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_offset <= OFFSET_W'(MAX_CHARS))
    else $error("end offset beyond limit");

endmodule

bind string_to_unsigned_parser string_to_unsigned_parser_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .parsed_value (parsed_value),
  .parse_done   (parse_done),
  .end_offset   (end_offset)
);

`default_nettype wire

// ===== verif/string_to_unsigned_parser_tb.sv =====
// self-checking testbench for the streaming string to unsigned integer parser
module string_to_unsigned_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stup_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int MAX_WAIT       = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int RANDOM_ITEMS   = 400;
  localparam int PHASES         = 10;
  localparam int MAX_SHOWN      = 10;

  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_ALNUM = 6'd36;
  localparam logic [BASE_W-1:0] BASE_TOP   = 6'd63;
  localparam logic [5:0]        NO_DIGIT   = 6'd36;
  localparam logic [CHAR_W-1:0] NUL        = 8'h00;
  localparam logic [ADDR_W-1:0] BASE_ADDR  = {REG_NUMBER_BASE, 2'b00};

  typedef enum logic [2:0] {
    SKIPPING_BLANKS,
    SIGN_TAKEN,
    SAW_ZERO_AUTO,
    SAW_ZERO_HEX,
    READING_DIGITS,
    FINISHED
  } scan_state_t;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [CHAR_W-1:0]      char_code;
  logic                   start_of_string;
  logic                   out_valid;
  logic                   out_stall;
  logic [VALUE_OUT_W-1:0] parsed_value;
  logic                   parse_done;
  logic [OFFSET_W-1:0]    end_offset;

  string_to_unsigned_parser DUT (.*);

  // predictor state
  logic [BASE_W-1:0]      base_reg;
  scan_state_t            scan_state;
  logic [BASE_W-1:0]      cur_base;
  logic [VALUE_OUT_W-1:0] acc_value;
  logic                   neg_sign;
  logic [OFFSET_W-1:0]    end_pos;

  result_t          expected_results[$];
  logic [CHAR_W-1:0] pending_text[$];

  int unsigned errors;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned results_seen;
  int unsigned config_writes;
  logic        steady_flow;
  logic        hold_pending;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [5:0] digit_of(logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 6'(c - "A" + 10);
    return NO_DIGIT;
  endfunction

  function automatic void bump_end();
    if (end_pos < MAX_CHARS) end_pos++;
  endfunction

  function automatic void take_digit(logic [CHAR_W-1:0] c);
    logic [5:0] d;
    d = digit_of(c);
    if (c == NUL || d == NO_DIGIT || d >= cur_base) begin
      scan_state = FINISHED;
    end else begin
      acc_value = acc_value * VALUE_OUT_W'(cur_base) + VALUE_OUT_W'(d);
      bump_end();
    end
  endfunction

  function automatic void take_prefix(logic [CHAR_W-1:0] c);
    if (cur_base == BASE_AUTO) begin
      if (c == "0") begin
        bump_end();
        scan_state = SAW_ZERO_AUTO;
        return;
      end
      cur_base = BASE_DEC;
    end else if (cur_base == BASE_HEX && c == "0") begin
      bump_end();
      scan_state = SAW_ZERO_HEX;
      return;
    end
    scan_state = READING_DIGITS;
    take_digit(c);
  endfunction

  // advance the parse by one character and queue the result it gives
  function automatic void predict_char(logic [CHAR_W-1:0] c, logic sos);
    result_t r;
    if (sos) begin
      scan_state = SKIPPING_BLANKS;
      cur_base   = base_reg;
      acc_value  = '0;
      neg_sign   = 1'b0;
      end_pos    = '0;
    end
    case (scan_state)
      SKIPPING_BLANKS: begin
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
          bump_end();
        end else if (c == "-" || c == "+") begin
          neg_sign = (c == "-");
          bump_end();
          scan_state = SIGN_TAKEN;
        end else begin
          take_prefix(c);
        end
      end
      SIGN_TAKEN: take_prefix(c);
      SAW_ZERO_AUTO: begin
        scan_state = READING_DIGITS;
        if (c == "x" || c == "X") begin
          cur_base = BASE_HEX;
          bump_end();
        end else begin
          cur_base = BASE_OCT;
          take_digit(c);
        end
      end
      SAW_ZERO_HEX: begin
        scan_state = READING_DIGITS;
        if (c == "x" || c == "X") bump_end();
        else take_digit(c);
      end
      READING_DIGITS: take_digit(c);
      default: scan_state = FINISHED;
    endcase
    r.parsed_value = neg_sign ? (VALUE_OUT_W'(0) - acc_value) : acc_value;
    r.parse_done   = (scan_state == FINISHED);
    r.end_offset   = end_pos;
    expected_results.push_back(r);
  endfunction

  function automatic void check_result();
    result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("unexpected result: value=%h done=%b offset=%0d",
                 parsed_value, parse_done, end_offset);
      return;
    end
    want = expected_results.pop_front();
    if (parsed_value !== want.parsed_value || parse_done !== want.parse_done ||
        end_offset !== want.end_offset) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("mismatch at result %0d: expected %h/%b/%0d, got %h/%b/%0d", results_seen,
                 want.parsed_value, want.parse_done, want.end_offset,
                 parsed_value, parse_done, end_offset);
    end
  endfunction

  // receiving side: checks each result transfer and draws its own stall
  initial begin : result_side
    int unsigned stall_left;
    logic        stall_next;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_result();
        stall_left = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      stall_next = (stall_left != 0);
      if (stall_left != 0) stall_left--;
      out_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // valid stays high into the next item when there is no gap
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic sos);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    char_code       <= c;
    start_of_string <= sos;
    do @(posedge clk); while (in_stall);
    predict_char(c, sos);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (pending_text[i]) send_char(pending_text[i], i == 0);
    strings_sent++;
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    strings_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_ADDR;
    pwdata  <= DATA_W'(b);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    base_reg = b;
    config_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 6);
    return (k > 4) ? 8'h20 : 8'(9 + k);
  endfunction

  function automatic logic [CHAR_W-1:0] hex_mark();
    return $urandom_range(0, 1) ? 8'("x") : 8'("X");
  endfunction

  // blanks, sign, prefix and digits of the current base, then a stop and junk
  function automatic void build_number();
    int unsigned radix;
    int unsigned n_digits;
    pending_text.delete();
    repeat ($urandom_range(0, 2)) pending_text.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: pending_text.push_back(8'("-"));
      1: pending_text.push_back(8'("+"));
      default: ;
    endcase
    radix = base_reg;
    if (base_reg == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          pending_text.push_back(8'("0"));
          pending_text.push_back(hex_mark());
          radix = BASE_HEX;
        end
        1: begin
          pending_text.push_back(8'("0"));
          radix = BASE_OCT;
        end
        default: radix = BASE_DEC;
      endcase
    end else if (base_reg == BASE_HEX && $urandom_range(0, 1)) begin
      pending_text.push_back(8'("0"));
      pending_text.push_back(hex_mark());
    end
    if (radix > BASE_ALNUM) radix = BASE_ALNUM;
    n_digits = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    repeat (n_digits) pending_text.push_back(digit_char($urandom_range(0, radix - 1)));
    case ($urandom_range(0, 2))
      0: pending_text.push_back(NUL);
      1: pending_text.push_back(8'("."));
      default: pending_text.push_back(8'($urandom_range(0, 255)));
    endcase
    repeat ($urandom_range(0, 2)) pending_text.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_noise();
    pending_text.delete();
    repeat ($urandom_range(1, 5)) pending_text.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_directed();
    // no start after reset: parse runs with auto-detect
    send_char(8'("4"), 1'b0);
    send_char(NUL, 1'b0);
    send_char(8'h20, 1'b1);
    send_char(8'h09, 1'b0);
    send_char(8'h0D, 1'b0);
    strings_sent += 2;
    send_word("-0xFg");
    send_word("078");
    // characters after the stop repeat the same result
    send_word("+9");
    send_char(NUL, 1'b0);
    send_char(8'("5"), 1'b0);
    // prefix with no digits, stopped by a code above 127
    send_word("0x");
    send_char(8'hFF, 1'b0);
    write_base(BASE_HEX);
    send_word("01");
    // a base change inside a string only applies from the next start
    send_char(8'("7"), 1'b1);
    write_base(BASE_BIN);
    send_char(8'("f"), 1'b0);
    write_base(BASE_TOP);
    send_word("z");
    send_char(NUL, 1'b0);
    write_base(BASE_ONE);
    send_word("01");
    write_base(BASE_ALNUM);
    send_word("-zZ!");
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_pending = 1'b1;
    steady_flow  = 1'b1;
    repeat (4) begin
      build_number();
      send_text();
    end
    steady_flow = 1'b0;
    // sender stays quiet until every result of the burst is back
    wait_idle();
  endtask

  task automatic test_random_strings();
    logic [BASE_W-1:0] plan [PHASES];
    int unsigned       phase_start;
    plan = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_OCT, BASE_BIN,
             BASE_ALNUM, BASE_AUTO, BASE_ONE, BASE_TOP, BASE_AUTO};
    plan[PHASES-1] = BASE_W'($urandom_range(0, 36));
    for (int k = 0; k < PHASES; k++) begin
      write_base(plan[k]);
      steady_flow = (k == 4);
      phase_start = chars_sent;
      while (chars_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 4) == 0) build_noise();
        else build_number();
        send_text();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : main
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid        <= 1'b0;
    char_code       <= '0;
    start_of_string <= 1'b0;
    base_reg      = BASE_AUTO;
    scan_state    = SKIPPING_BLANKS;
    cur_base      = BASE_AUTO;
    acc_value     = '0;
    neg_sign      = 1'b0;
    end_pos       = '0;
    errors        = 0;
    chars_sent    = 0;
    strings_sent  = 0;
    results_seen  = 0;
    config_writes = 0;
    steady_flow   = 1'b0;
    hold_pending  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_strings();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("covered %0d strings, %0d characters, %0d results checked, %0d base writes",
             strings_sent, chars_sent, results_seen, config_writes);
    $display("included a held-off output, a no-gap stretch and a full drain pause; %0d errors",
             errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== string_to_unsigned_parser.f =====
rtl/stup_pkg.sv
rtl/stup_engine.sv
rtl/string_to_unsigned_parser.sv
rtl/string_to_unsigned_parser_checker.sv
verif/string_to_unsigned_parser_tb.sv
